>>> rtl/core/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg: shared types, constants and helpers of the DCF77 frame encoder
// Holds the frame layout, symbol and register codes and the BCD conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcf_pkg;

  // Bits 0..58 of a minute frame; second 59 is the no-pulse marker.
  localparam int FRAME_BITS = 59;
  localparam int FRAME_LEN  = 60;
  localparam int SEC_W      = 6;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_ONE  = 2'd1,
    SYM_NONE = 2'd2
  } symbol_t;

  typedef enum logic [1:0] {
    REG_WARNING = 2'd0,
    REG_SUMMER  = 2'd1,
    REG_LEAP    = 2'd2
  } reg_idx_t;

  localparam logic [14:0] WARNING_RST = 15'h7FFF;
  localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(FRAME_LEN - 1);

  // Packed BCD of a value 0..99; tens digit by multiply with reciprocal 103/1024.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rest;
    prod = 14'(v) * 14'd103;
    tens = prod[13:10];
    rest = v - 7'(tens) * 7'd10;
    return {tens, rest[3:0]};
  endfunction

endpackage

>>> rtl/core/dcf_front.sv
// ----------------------------------------------------------------------------
// dcf_front: configuration registers and frame assembly
// Clamps one date and time item and builds the 59 data bits of its frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcf_pkg::ADDR_W-1:0]  paddr,
  input  logic [dcf_pkg::DATA_W-1:0]  pwdata,
  output logic [dcf_pkg::DATA_W-1:0]  prdata,
  // item
  input  logic [5:0]                  minute,
  input  logic [4:0]                  hour,
  input  logic [4:0]                  day_of_month,
  input  logic [2:0]                  weekday,
  input  logic [3:0]                  month,
  input  logic [6:0]                  year,
  input  logic                        summer_time,
  output dcf_pkg::frame_t             frame
);

  logic [14:0] warning_r;
  logic        summer_ann_r;
  logic        leap_ann_r;
  logic        wr_en;
  dcf_pkg::reg_idx_t reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = dcf_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warning_r    <= dcf_pkg::WARNING_RST;
      summer_ann_r <= 1'b0;
      leap_ann_r   <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        dcf_pkg::REG_WARNING: warning_r    <= pwdata[14:0];
        dcf_pkg::REG_SUMMER:  summer_ann_r <= pwdata[0];
        dcf_pkg::REG_LEAP:    leap_ann_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dcf_pkg::REG_WARNING: prdata = {17'd0, warning_r};
      dcf_pkg::REG_SUMMER:  prdata = {31'd0, summer_ann_r};
      dcf_pkg::REG_LEAP:    prdata = {31'd0, leap_ann_r};
      default:              prdata = '0;
    endcase
  end

  // Clamped fields
  logic [6:0] min_c, hour_c, day_c, mon_c, year_c;
  logic [2:0] wday_c;
  logic [7:0] min_b, hour_b, day_b, mon_b, year_b;
  logic       par_min, par_hour, par_date;

  always_comb begin
    min_c  = (minute > 6'd59) ? 7'd59 : 7'(minute);
    hour_c = (hour > 5'd23) ? 7'd23 : 7'(hour);
    day_c  = (day_of_month == 5'd0) ? 7'd1 : 7'(day_of_month);
    mon_c  = (month == 4'd0) ? 7'd1 : (month > 4'd12) ? 7'd12 : 7'(month);
    year_c = (year > 7'd99) ? 7'd99 : year;
    // Sunday goes out as 7; the unused code 7 clamps to Saturday.
    wday_c = (weekday == 3'd0) ? 3'd7 : (weekday == 3'd7) ? 3'd6 : weekday;

    min_b  = dcf_pkg::to_bcd(min_c);
    hour_b = dcf_pkg::to_bcd(hour_c);
    day_b  = dcf_pkg::to_bcd(day_c);
    mon_b  = dcf_pkg::to_bcd(mon_c);
    year_b = dcf_pkg::to_bcd(year_c);

    par_min  = ^min_b[6:0];
    par_hour = ^hour_b[5:0];
    par_date = ^{day_b[5:0], wday_c, mon_b[4:0], year_b};

    frame = {par_date, year_b, mon_b[4:0], wday_c, day_b[5:0],
             par_hour, hour_b[5:0], par_min, min_b[6:0],
             1'b1, leap_ann_r, ~summer_time, summer_time, summer_ann_r,
             warning_r, 1'b0};
  end

endmodule

>>> rtl/core/dcf_queue.sv
// ----------------------------------------------------------------------------
// dcf_queue: frame queue between assembly and serializer
// A small register FIFO of assembled frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcf_queue #(
  parameter int DEPTH = dcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dcf_pkg::frame_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output dcf_pkg::frame_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dcf_pkg::frame_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/dcf_back.sv
// ----------------------------------------------------------------------------
// dcf_back: symbol serializer
// Sends the 60 symbols of each queued frame through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_not_empty,
  input  dcf_pkg::frame_t             q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_symbol,
  output logic [dcf_pkg::SEC_W-1:0]   out_second_index,
  output logic                        out_last_of_frame
);

  dcf_pkg::frame_t            frame_r;
  logic                       busy_r, busy_nxt;
  logic [dcf_pkg::SEC_W-1:0]  sec_r, sec_nxt;
  logic                       out_valid_r;
  logic [1:0]                 out_symbol_r;
  logic [dcf_pkg::SEC_W-1:0]  out_sec_r;
  logic                       out_last_r;
  logic                       advance;
  logic                       at_last;
  dcf_pkg::symbol_t           sym;

  assign advance = busy_r & (~out_valid_r | ~out_stall);
  assign at_last = (sec_r == dcf_pkg::LAST_SEC);
  // The next frame loads on the cycle its predecessor hands over its marker.
  assign q_pop   = q_not_empty & (~busy_r | (advance & at_last));

  always_comb begin
    if (at_last) begin
      sym = dcf_pkg::SYM_NONE;
    end else if (frame_r[sec_r]) begin
      sym = dcf_pkg::SYM_ONE;
    end else begin
      sym = dcf_pkg::SYM_ZERO;
    end

    busy_nxt = busy_r;
    sec_nxt  = sec_r;
    if (advance) begin
      sec_nxt = sec_r + 1'b1;
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      sec_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      sec_r  <= sec_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      frame_r <= q_data;
    end
    if (advance) begin
      out_symbol_r <= sym;
      out_sec_r    <= sec_r;
      out_last_r   <= at_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_symbol        = out_symbol_r;
  assign out_second_index  = out_sec_r;
  assign out_last_of_frame = out_last_r;

endmodule

>>> rtl/core/dcf77_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// dcf77_frame_encoder_top: DCF77 minute frame encoder
// Turns one date and time item into the 60 second symbols of its frame.
// ----------------------------------------------------------------------------
// An item goes through the frame queue and the serializer frame register to
// the output register. One symbol per cycle leaves while out_stall is low.
// The frame queue holds QUEUE_DEPTH frames, so input is taken while a frame
// is still being sent. Reset empties the queue and serializer and loads the
// registers with warning_bits 0x7FFF, summer_announce 0 and leap_announce 0.
`timescale 1ns / 1ps

module dcf77_frame_encoder_top #(
  parameter int QUEUE_DEPTH = dcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcf_pkg::ADDR_W-1:0]  paddr,
  input  logic [dcf_pkg::DATA_W-1:0]  pwdata,
  output logic [dcf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [5:0]                  in_minute,
  input  logic [4:0]                  in_hour,
  input  logic [4:0]                  in_day_of_month,
  input  logic [2:0]                  in_weekday,
  input  logic [3:0]                  in_month,
  input  logic [6:0]                  in_year,
  input  logic                        in_summer_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_symbol,
  output logic [dcf_pkg::SEC_W-1:0]   out_second_index,
  output logic                        out_last_of_frame
);

  dcf_pkg::frame_t frame;
  dcf_pkg::frame_t q_data;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;

  assign pready   = 1'b1;
  assign in_stall = q_full;

  dcf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .minute       (in_minute),
    .hour         (in_hour),
    .day_of_month (in_day_of_month),
    .weekday      (in_weekday),
    .month        (in_month),
    .year         (in_year),
    .summer_time  (in_summer_time),
    .frame        (frame)
  );

  dcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (frame),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  dcf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_symbol        (out_symbol),
    .out_second_index  (out_second_index),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the DCF77 minute frame encoder
// Directed and random date items are sent and every second symbol is checked
// against a frame predictor. Register settings, idle and stall patterns vary
// from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 100;
  localparam int DIR_ROWS    = 17;

  // Register index with no register behind it; writes to it must be ignored.
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [2:0] wday;
    logic [3:0] month;
    logic [6:0] year;
    logic       summer;
  } date_t;

  typedef struct packed {
    dcf_pkg::symbol_t          symbol;
    logic [dcf_pkg::SEC_W-1:0] second;
    logic                      last;
  } sym_rec_t;

  typedef struct packed {
    date_t           d;
    logic            typed;
    dcf_pkg::frame_t frame;
  } dir_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [dcf_pkg::ADDR_W-1:0] paddr = '0;
  logic [dcf_pkg::DATA_W-1:0] pwdata = '0;
  logic [dcf_pkg::DATA_W-1:0] prdata;
  logic                       pready;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  date_t                      in_date = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 out_symbol;
  logic [dcf_pkg::SEC_W-1:0]  out_second_index;
  logic                       out_last_of_frame;

  // Register copies used by the frame predictor.
  logic [14:0] warn_bits = dcf_pkg::WARNING_RST;
  logic        summer_ann = 1'b0;
  logic        leap_ann = 1'b0;

  sym_rec_t pending_symbols[$];
  sym_rec_t want_sym;
  int       err_cnt = 0;
  int       cycle_cnt = 0;
  int       send_idle_pct = 0;
  int       stall_pct = 0;
  logic     hold_off = 1'b0;

  // Three frames are typed in: all fields zero, all fields at their top code
  // and all fields at their top legal value, all under the reset register values.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{6'd0, 5'd0, 5'd0, 3'd0, 4'd0, 7'd0, 1'b0}, 1'b1, 59'h400_3C10_0014_FFFE},
    '{'{6'd63, 5'd31, 5'd31, 3'd7, 4'd15, 7'd127, 1'b1}, 1'b1,
      59'h666_5B1C_6B32_FFFE},
    '{'{6'd59, 5'd23, 5'd31, 3'd6, 4'd12, 7'd99, 1'b1}, 1'b1,
      59'h666_5B1C_6B32_FFFE},
    '{'{6'd0, 5'd0, 5'd1, 3'd0, 4'd1, 7'd0, 1'b0}, 1'b0, '0},
    '{'{6'd60, 5'd24, 5'd0, 3'd7, 4'd0, 7'd100, 1'b0}, 1'b0, '0},
    '{'{6'd60, 5'd24, 5'd0, 3'd7, 4'd13, 7'd100, 1'b1}, 1'b0, '0},
    '{'{6'd15, 5'd8, 5'd9, 3'd1, 4'd3, 7'd21, 1'b1}, 1'b0, '0},
    '{'{6'd30, 5'd12, 5'd10, 3'd2, 4'd6, 7'd45, 1'b0}, 1'b0, '0},
    '{'{6'd45, 5'd17, 5'd19, 3'd3, 4'd9, 7'd50, 1'b1}, 1'b0, '0},
    '{'{6'd1, 5'd1, 5'd2, 3'd4, 4'd10, 7'd88, 1'b0}, 1'b0, '0},
    '{'{6'd38, 5'd19, 5'd29, 3'd5, 4'd11, 7'd77, 1'b1}, 1'b0, '0},
    '{'{6'd58, 5'd22, 5'd30, 3'd6, 4'd12, 7'd98, 1'b0}, 1'b0, '0},
    '{'{6'd42, 5'd21, 5'd5, 3'd1, 4'd2, 7'd36, 1'b1}, 1'b0, '0},
    '{'{6'd3, 5'd3, 5'd3, 3'd3, 4'd3, 7'd3, 1'b0}, 1'b0, '0},
    '{'{6'h2A, 5'h15, 5'h0A, 3'h5, 4'h5, 7'h55, 1'b0}, 1'b0, '0},
    '{'{6'h15, 5'h0A, 5'h15, 3'h2, 4'hA, 7'h2A, 1'b1}, 1'b0, '0},
    '{'{6'd9, 5'd9, 5'd31, 3'd0, 4'd12, 7'd9, 1'b1}, 1'b0, '0}
  };

  dcf77_frame_encoder_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_minute         (in_date.minute),
    .in_hour           (in_date.hour),
    .in_day_of_month   (in_date.day),
    .in_weekday        (in_date.wday),
    .in_month          (in_date.month),
    .in_year           (in_date.year),
    .in_summer_time    (in_date.summer),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_symbol        (out_symbol),
    .out_second_index  (out_second_index),
    .out_last_of_frame (out_last_of_frame)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d symbols still pending", $time, pending_symbols.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Builds the 59 data bits of a minute frame, bit k going out in second k.
  function automatic dcf_pkg::frame_t encode_frame(date_t d);
    dcf_pkg::frame_t f;
    int unsigned     vals [6];
    int unsigned     widths [6];
    int unsigned     m, h, dy, wd, mo, yr;
    int              p, g, i;
    logic [7:0]      code;
    logic            par;
    m  = (d.minute > 59) ? 59 : d.minute;
    h  = (d.hour > 23) ? 23 : d.hour;
    dy = (d.day == 0) ? 1 : d.day;
    wd = (d.wday > 6) ? 6 : d.wday;
    mo = (d.month == 0) ? 1 : ((d.month > 12) ? 12 : d.month);
    yr = (d.year > 99) ? 99 : d.year;
    vals = '{m, h, dy, (wd == 0) ? 7 : wd, mo, yr};
    widths = '{7, 6, 6, 3, 5, 8};
    f = '0;
    f[15:1] = warn_bits;
    f[16] = summer_ann;
    f[17] = d.summer;
    f[18] = ~d.summer;
    f[19] = leap_ann;
    f[20] = 1'b1;
    p = 21;
    par = 1'b0;
    for (g = 0; g < 6; g++) begin
      code = 8'(((vals[g] / 10) << 4) | (vals[g] % 10));
      for (i = 0; i < widths[g]; i++) begin
        f[p] = code[i];
        par ^= code[i];
        p++;
      end
      // Minute and hour carry their own parity; the date fields share one.
      if (g == 0 || g == 1 || g == 5) begin
        f[p] = par;
        p++;
        par = 1'b0;
      end
    end
    return f;
  endfunction

  function automatic date_t rand_date();
    date_t d;
    if ($urandom_range(9) < 8) begin
      d.minute = 6'($urandom_range(59));
      d.hour   = 5'($urandom_range(23));
      d.day    = 5'($urandom_range(31, 1));
      d.wday   = 3'($urandom_range(6));
      d.month  = 4'($urandom_range(12, 1));
      d.year   = 7'($urandom_range(99));
    end else begin
      d.minute = 6'($urandom);
      d.hour   = 5'($urandom);
      d.day    = 5'($urandom);
      d.wday   = 3'($urandom);
      d.month  = 4'($urandom);
      d.year   = 7'($urandom);
    end
    d.summer = 1'($urandom);
    return d;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_frame(date_t d, logic typed, dcf_pkg::frame_t typed_frame);
    int              gap;
    int              k;
    dcf_pkg::frame_t f;
    sym_rec_t        rec;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_date <= d;
    do @(posedge clk); while (in_stall);
    f = typed ? typed_frame : encode_frame(d);
    for (k = 0; k < dcf_pkg::FRAME_BITS; k++) begin
      rec.symbol = f[k] ? dcf_pkg::SYM_ONE : dcf_pkg::SYM_ZERO;
      rec.second = k[dcf_pkg::SEC_W-1:0];
      rec.last   = 1'b0;
      pending_symbols.push_back(rec);
    end
    rec.symbol = dcf_pkg::SYM_NONE;
    rec.second = dcf_pkg::LAST_SEC;
    rec.last   = 1'b1;
    pending_symbols.push_back(rec);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_symbols.size() != 0);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [dcf_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      dcf_pkg::REG_WARNING: warn_bits = val[14:0];
      dcf_pkg::REG_SUMMER:  summer_ann = val[0];
      dcf_pkg::REG_LEAP:    leap_ann = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_read_check(logic [1:0] idx, logic [dcf_pkg::DATA_W-1:0] want);
    logic [dcf_pkg::DATA_W-1:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $display("%0t: register %0d read: expected %h, got %h", $time, idx, want, got);
      err_cnt++;
    end
  endtask

  // Called only while nothing is in flight. The unmapped write must not
  // disturb any of the real registers.
  task automatic set_registers(logic [14:0] w, logic s, logic l);
    cfg_write(dcf_pkg::REG_WARNING, {$urandom} << 15 | 32'(w));
    cfg_write(dcf_pkg::REG_SUMMER, {$urandom} << 1 | 32'(s));
    cfg_write(dcf_pkg::REG_LEAP, {$urandom} << 1 | 32'(l));
    cfg_write(REG_UNMAPPED, $urandom);
    cfg_read_check(dcf_pkg::REG_WARNING, 32'(warn_bits));
    cfg_read_check(dcf_pkg::REG_SUMMER, 32'(summer_ann));
    cfg_read_check(dcf_pkg::REG_LEAP, 32'(leap_ann));
  endtask

  task automatic run_phase(int idle_pct, int stall_pct_v, logic with_hold);
    int n;
    send_idle_pct = idle_pct;
    stall_pct = stall_pct_v;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      // The receiver holds off while the sender keeps offering, which fills
      // the frame queue and must back-pressure the input.
      if (with_hold && n == PHASE_ITEMS / 4) begin
        fork
          begin
            @(posedge clk);
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      send_frame(rand_date(), 1'b0, '0);
    end
    wait_drain();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_symbols.size() == 0) begin
        $display("%0t: unexpected transaction: symbol %0d second %0d last %0d", $time,
                 out_symbol, out_second_index, out_last_of_frame);
        err_cnt++;
      end else begin
        want_sym = pending_symbols.pop_front();
        if (out_symbol !== want_sym.symbol) begin
          $display("%0t: second %0d symbol: expected %0d, got %0d", $time,
                   want_sym.second, want_sym.symbol, out_symbol);
          err_cnt++;
        end
        if (out_second_index !== want_sym.second) begin
          $display("%0t: second_index: expected %0d, got %0d", $time,
                   want_sym.second, out_second_index);
          err_cnt++;
        end
        if (out_last_of_frame !== want_sym.last) begin
          $display("%0t: second %0d last_of_frame: expected %0d, got %0d", $time,
                   want_sym.second, want_sym.last, out_last_of_frame);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int r;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    cfg_read_check(dcf_pkg::REG_WARNING, 32'(dcf_pkg::WARNING_RST));
    cfg_read_check(dcf_pkg::REG_SUMMER, 32'd0);
    cfg_read_check(dcf_pkg::REG_LEAP, 32'd0);

    // Directed rows run under the reset register values.
    for (r = 0; r < DIR_ROWS; r++) begin
      send_frame(dir_tab[r].d, dir_tab[r].typed, dir_tab[r].frame);
    end
    wait_drain();

    set_registers(15'h0000, 1'b1, 1'b1);
    run_phase(0, 0, 1'b0);
    set_registers(15'($urandom), 1'b0, 1'b1);
    run_phase(67, 0, 1'b0);
    set_registers(15'h7FFF, 1'b1, 1'b0);
    run_phase(0, 67, 1'b0);
    set_registers(15'($urandom), 1'($urandom), 1'($urandom));
    run_phase(15, 15, 1'b1);

    repeat (20) @(posedge clk);
    if (err_cnt == 0 && pending_symbols.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
